@@ sv/soil_moisture_average_map_ema_defines.svh @@
// assertion macros used by the checker file of the soil moisture block
`ifndef SOIL_MOISTURE_AVERAGE_MAP_EMA_DEFINES_SVH
`define SOIL_MOISTURE_AVERAGE_MAP_EMA_DEFINES_SVH

// antecedent holds, consequent must hold in the same cycle
`define SMAE_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// antecedent holds, consequent must hold in the next cycle
`define SMAE_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ sv/smae_pkg.sv @@
// shared widths, constants and control types of the soil moisture block
package smae_pkg;

   localparam int ADC_W       = 12;
   localparam int CFG_W       = 12;
   localparam int WEIGHT_W    = 9;
   localparam int MOIST_W     = 15;
   localparam int NUM_W       = 27;
   localparam int DEN_W       = 12;
   localparam int PROD_W      = 24;
   localparam int CSR_ADDR_W  = 2;
   localparam int REQ_DATA_W  = 16;
   localparam int RSP_DATA_W  = 48;
   localparam int SAMPLES_DEF = 16;

   localparam logic [MOIST_W-1:0]  FULL_SCALE   = 15'd25600;
   localparam logic [WEIGHT_W-1:0] WEIGHT_ONE   = 9'd256;
   localparam logic [ADC_W-1:0]    DRY_RESET    = 12'd4095;
   localparam logic [ADC_W-1:0]    WET_RESET    = 12'd0;
   localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = 9'd51;

   // configuration register indexes
   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_DRY    = 2'd0,
      CSR_WET    = 2'd1,
      CSR_WEIGHT = 2'd2
   } csr_index_type;

   // commands from controller to datapath
   typedef struct packed {
      logic accum;
      logic avg_start;
      logic clamp;
      logic scale;
      logic map_start;
      logic ema_mult;
      logic emit;
   } smae_cmd_type;

   // status from datapath to controller
   typedef struct packed {
      logic last;
      logic div_done;
      logic out_free;
   } smae_status_type;

endpackage

@@ sv/smae_div.sv @@
// restoring divider, one quotient bit per cycle
module smae_div
   import smae_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] dividend,
   input  logic [DEN_W-1:0] divisor,
   output logic             done,
   output logic [NUM_W-1:0] quotient
);

   localparam int STEP_W = $clog2(NUM_W);

   logic              busy_ff, busy_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [NUM_W-1:0]  dq_ff, dq_in;
   logic [DEN_W-1:0]  rem_ff, rem_in;
   logic [DEN_W-1:0]  den_ff, den_in;
   logic [DEN_W:0]    trial;
   logic [DEN_W:0]    diff;
   logic              ge;

   // one shift-and-subtract step
   assign trial = {rem_ff, dq_ff[NUM_W-1]};
   assign ge    = trial >= {1'b0, den_ff};
   assign diff  = trial - {1'b0, den_ff};
   assign done  = busy_ff && (step_ff == STEP_W'(NUM_W - 1));
   assign quotient = dq_ff;

   // next state of the iteration
   always_comb begin
      busy_in = busy_ff;
      step_in = step_ff;
      dq_in   = dq_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         dq_in   = dividend;
         rem_in  = '0;
         den_in  = divisor;
      end else if (busy_ff) begin
         rem_in  = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
         dq_in   = {dq_ff[NUM_W-2:0], ge};
         step_in = step_ff + STEP_W'(1);
         if (done) begin
            busy_in = 1'b0;
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         step_ff <= step_in;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      dq_ff  <= dq_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

endmodule

@@ sv/smae_ctrl.sv @@
// controller state machine sequencing accumulation, division, mapping and output
module smae_ctrl
   import smae_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_tvalid,
   output logic            req_tready,
   input  smae_status_type status,
   output smae_cmd_type    cmd
);

   typedef enum logic [7:0] {
      S_ACCUM     = 8'b00000001,
      S_AVG_START = 8'b00000010,
      S_CLAMP     = 8'b00000100,
      S_SCALE     = 8'b00001000,
      S_MAP_START = 8'b00010000,
      S_MAP_WAIT  = 8'b00100000,
      S_EMA_MULT  = 8'b01000000,
      S_EMIT      = 8'b10000000
   } state_type;

   state_type state_ff, state_in;

   assign req_tready = (state_ff == S_ACCUM);

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_ACCUM: begin
            if (req_tvalid) begin
               cmd.accum = 1'b1;
               if (status.last) begin
                  state_in = S_AVG_START;
               end
            end
         end
         S_AVG_START: begin
            cmd.avg_start = 1'b1;
            state_in      = S_CLAMP;
         end
         S_CLAMP: begin
            cmd.clamp = 1'b1;
            state_in  = S_SCALE;
         end
         S_SCALE: begin
            cmd.scale = 1'b1;
            state_in  = S_MAP_START;
         end
         S_MAP_START: begin
            cmd.map_start = 1'b1;
            state_in      = S_MAP_WAIT;
         end
         S_MAP_WAIT: begin
            if (status.div_done) begin
               state_in = S_EMA_MULT;
            end
         end
         S_EMA_MULT: begin
            cmd.ema_mult = 1'b1;
            state_in     = S_EMIT;
         end
         S_EMIT: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               state_in = S_ACCUM;
            end
         end
         default: begin
            state_in = S_ACCUM;
         end
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_ACCUM;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

@@ sv/smae_dpath.sv @@
// datapath: calibration registers, accumulator, mapping, moving average, output word
module smae_dpath
   import smae_pkg::*;
#(
   parameter int SAMPLES = SAMPLES_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  smae_cmd_type          cmd,
   output smae_status_type       status,
   input  logic [ADC_W-1:0]      sample,
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CFG_W-1:0]      csr_wdata,
   input  logic                  rsp_tready,
   output logic                  rsp_tvalid,
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic                  rsp_tuser
);

   localparam int CNT_W   = (SAMPLES > 1) ? $clog2(SAMPLES) : 1;
   localparam int SUM_W   = ADC_W + $clog2(SAMPLES);
   localparam int MEAN_SH = SUM_W + $clog2(SAMPLES);
   localparam int RECIP_W = SUM_W + 1;
   localparam int MPROD_W = SUM_W + RECIP_W;
   localparam logic [RECIP_W-1:0] MEAN_RECIP =
      RECIP_W'(((64'd1 << MEAN_SH) + 64'(SAMPLES) - 64'd1) / 64'(SAMPLES));

   // calibration registers
   logic [ADC_W-1:0]    dry_ff, wet_ff;
   logic [WEIGHT_W-1:0] weight_ff;

   // block state
   logic [SUM_W-1:0]   sum_ff, sum_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [MOIST_W-1:0] ema_ff, ema_in;
   logic               seeded_ff, seeded_in;

   // per-block working registers
   logic [ADC_W-1:0]   avg_ff;
   logic [ADC_W-1:0]   diff_ff;
   logic               err_ff;
   logic [NUM_W-1:0]   num_ff;
   logic [MOIST_W-1:0] raw_ff;
   logic [PROD_W-1:0]  pa_ff, pb_ff;

   // output word
   logic               out_valid_ff, out_valid_in;
   logic [ADC_W-1:0]   out_avg_ff;
   logic [MOIST_W-1:0] out_raw_ff, out_filt_ff;
   logic               out_err_ff;

   logic               div_start, div_done;
   logic [NUM_W-1:0]   div_dividend, div_quotient;
   logic [DEN_W-1:0]   div_divisor;
   logic [MPROD_W-1:0] mean_prod;
   logic [ADC_W-1:0]   q_avg, clamped;
   logic [MOIST_W-1:0] raw_val;
   logic [WEIGHT_W-1:0] w_sat, w_inv;
   logic [PROD_W-1:0]  ema_sum;
   logic [MOIST_W-1:0] ema_new;
   logic               last;

   // configuration writes, unknown indexes dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         dry_ff    <= DRY_RESET;
         wet_ff    <= WET_RESET;
         weight_ff <= WEIGHT_RESET;
      end else if (csr_we) begin
         unique case (csr_addr)
            CSR_DRY:    dry_ff    <= csr_wdata[ADC_W-1:0];
            CSR_WET:    wet_ff    <= csr_wdata[ADC_W-1:0];
            CSR_WEIGHT: weight_ff <= csr_wdata[WEIGHT_W-1:0];
            default: ;
         endcase
      end
   end

   // sample accumulation
   assign last = (cnt_ff == CNT_W'(SAMPLES - 1));

   always_comb begin
      sum_in = sum_ff;
      cnt_in = cnt_ff;
      if (cmd.accum) begin
         sum_in = sum_ff + SUM_W'(sample);
         cnt_in = last ? '0 : cnt_ff + CNT_W'(1);
      end else if (cmd.avg_start) begin
         sum_in = '0;
      end
   end

   // block mean by reciprocal multiply, exact over the whole sum range
   assign mean_prod = MPROD_W'(sum_ff) * MPROD_W'(MEAN_RECIP);
   assign q_avg     = mean_prod[MEAN_SH +: ADC_W];

   // divider for the calibrated mapping
   assign div_start    = cmd.map_start;
   assign div_dividend = num_ff;
   assign div_divisor  = dry_ff - wet_ff;

   smae_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quotient)
   );

   // clamp the mean between wet and dry codes
   always_comb begin
      clamped = avg_ff;
      if (clamped < wet_ff) begin
         clamped = wet_ff;
      end
      if (clamped > dry_ff) begin
         clamped = dry_ff;
      end
   end

   // moving average weights and products
   assign raw_val = err_ff ? '0 : div_quotient[MOIST_W-1:0];
   assign w_sat   = (weight_ff > WEIGHT_ONE) ? WEIGHT_ONE : weight_ff;
   assign w_inv   = WEIGHT_ONE - w_sat;
   assign ema_sum = pa_ff + pb_ff;
   assign ema_new = ema_sum[8 +: MOIST_W];

   always_comb begin
      ema_in    = ema_ff;
      seeded_in = seeded_ff;
      if (cmd.emit) begin
         ema_in    = seeded_ff ? ema_new : raw_ff;
         seeded_in = 1'b1;
      end
   end

   // per-block working registers
   always_ff @(posedge clock) begin
      if (cmd.avg_start) begin
         avg_ff <= q_avg;
      end
      if (cmd.clamp) begin
         diff_ff <= dry_ff - clamped;
         err_ff  <= (dry_ff <= wet_ff);
      end
      if (cmd.scale) begin
         num_ff <= NUM_W'(diff_ff) * NUM_W'(FULL_SCALE);
      end
      if (cmd.ema_mult) begin
         raw_ff <= raw_val;
         pa_ff  <= PROD_W'(w_sat) * PROD_W'(raw_val);
         pb_ff  <= PROD_W'(w_inv) * PROD_W'(ema_ff);
      end
   end

   // output word register, freed when taken
   assign status.out_free = !out_valid_ff || rsp_tready;
   assign status.last     = last;
   assign status.div_done = div_done;

   always_comb begin
      out_valid_in = out_valid_ff;
      if (cmd.emit) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         out_avg_ff  <= avg_ff;
         out_raw_ff  <= raw_ff;
         out_filt_ff <= ema_in;
         out_err_ff  <= err_ff;
      end
   end

   // block state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff       <= '0;
         cnt_ff       <= '0;
         ema_ff       <= '0;
         seeded_ff    <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         sum_ff       <= sum_in;
         cnt_ff       <= cnt_in;
         ema_ff       <= ema_in;
         seeded_ff    <= seeded_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W - ADC_W - 2 * MOIST_W){1'b0}},
                        out_filt_ff, out_raw_ff, out_avg_ff};
   assign rsp_tuser  = out_err_ff;

endmodule

@@ sv/soil_moisture_average_map_ema.sv @@
// top level of the soil moisture averaging, mapping and moving average block
//
// Input stream req_*: one 12-bit converter sample per word. Samples are summed
// in blocks of SAMPLES words; while a block is being collected one word is
// taken every cycle.
// After the last word of a block the input stalls (req_tready low) through
// the block mean (reciprocal multiply), the clamp, the scale multiply and the
// divider start, the divider running the calibrated moisture mapping, the
// moving average multiply and the output step.
// Output stream rsp_*: one word per block, shown after the output step of that
// block. The word sits in an output register; if the receiver stalls, the next
// block is still collected and only its final step waits.
// Configuration: csr_we writes csr_wdata to register csr_addr (0 dry code,
// 1 wet code, 2 moving average weight); other indexes are dropped. Write
// only while no block result is pending.
// Reset (synchronous) restores the calibration defaults, clears the sum,
// count and moving average and drops any pending output word.
module soil_moisture_average_map_ema
   import smae_pkg::*;
#(
   parameter int SAMPLES = SAMPLES_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   // adc_sample [11:0]
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // average_code [11:0], raw_moisture [26:12], filtered_moisture [41:27]
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // calib_error [0]
   output logic                  rsp_tuser,
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CFG_W-1:0]      csr_wdata
);

   smae_cmd_type    cmd;
   smae_status_type status;

   // sequencer
   smae_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   // arithmetic and storage
   smae_dpath #(
      .SAMPLES (SAMPLES)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .sample     (req_tdata[ADC_W-1:0]),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

@@ sv/smae_checker.sv @@
// port-level checks of the soil moisture block and their bind
`include "soil_moisture_average_map_ema_defines.svh"

module smae_checker
   import smae_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tvalid,
   input logic                  req_tready,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata,
   input logic                  rsp_tuser
);

   // a stalled result word holds
   `SMAE_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser), "stalled result word changed")

   // bad calibration gives zero raw moisture
   `SMAE_ASSERT_SAME(a_err_zero, clock, reset, rsp_tvalid && rsp_tuser, rsp_tdata[26:12] == '0, "raw moisture not zero on calibration error")

   // moisture values stay within full scale
   `SMAE_ASSERT_SAME(a_full_scale, clock, reset, rsp_tvalid, (rsp_tdata[26:12] <= FULL_SCALE) && (rsp_tdata[41:27] <= FULL_SCALE), "moisture above full scale")

   // no result can follow directly on a taken sample
   `SMAE_ASSERT_NEXT(a_no_early_rsp, clock, reset, req_tvalid && req_tready && !rsp_tvalid, !rsp_tvalid, "result appeared right after a sample")

endmodule

bind soil_moisture_average_map_ema smae_checker u_smae_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

@@ sim/soil_moisture_average_map_ema_tb.sv @@
`timescale 1ns / 1ps
// self-checking testbench of the soil moisture averaging, mapping and moving average block
module soil_moisture_average_map_ema_tb;
   import smae_pkg::*;

   localparam int SAMPLES      = SAMPLES_DEF;
   localparam int PHASES       = 12;
   localparam int PHASE_WORDS  = 120;
   localparam int DRAIN_CYCLES = 100;
   localparam int HOLD_CYCLES  = 500;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int ADC_MAX      = 4095;

   // index past the last register, must be dropped by the block
   localparam logic [CSR_ADDR_W-1:0] CSR_SPARE = 2'd3;

   // one block reading as carried by a result word
   typedef struct packed {
      logic [ADC_W-1:0]   mean_code;
      logic [MOIST_W-1:0] raw_pct;
      logic [MOIST_W-1:0] ema_pct;
      logic               calib_bad;
   } moisture_reading_type;

   logic                  clock;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tuser;
   logic                  csr_we = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_addr = '0;
   logic [CFG_W-1:0]      csr_wdata = '0;

   soil_moisture_average_map_ema dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   // calibration copy and block state of the predictor
   logic [ADC_W-1:0]    dry_code   = DRY_RESET;
   logic [ADC_W-1:0]    wet_code   = WET_RESET;
   logic [WEIGHT_W-1:0] ema_weight = WEIGHT_RESET;
   logic [17:0]         block_sum  = '0;
   int                  block_count = 0;
   logic [MOIST_W-1:0]  ema_pct    = '0;
   bit                  ema_seeded = 1'b0;

   logic [ADC_W-1:0]     sample_queue[$];
   moisture_reading_type expected_readings[$];

   int mismatches     = 0;
   int accepted_words = 0;
   int cycles         = 0;

   // driver and receiver pacing state
   int gap_left     = 0;
   int burst_left   = 0;
   int hold_left    = 0;
   int hold_count   = 0;
   int pattern_mode = 0;
   int pattern_left = 0;

   // clock
   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // add one sample to the block, predict the reading when the block closes
   task automatic accumulate_sample(input logic [ADC_W-1:0] sample);
      int unsigned          mean, clamped, raw, w, dry_u, wet_u, next_ema;
      moisture_reading_type r;
      block_sum = block_sum + 18'(sample);
      block_count++;
      if (block_count == SAMPLES) begin
         mean = block_sum / SAMPLES;
         block_sum = '0;
         block_count = 0;
         dry_u = 32'(dry_code);
         wet_u = 32'(wet_code);
         // inverse linear map, dry gives 0 and wet gives full scale
         if (dry_u <= wet_u) begin
            raw = 0;
            r.calib_bad = 1'b1;
         end else begin
            clamped = mean;
            if (clamped < wet_u) clamped = wet_u;
            if (clamped > dry_u) clamped = dry_u;
            raw = ((dry_u - clamped) * 25600) / (dry_u - wet_u);
            r.calib_bad = 1'b0;
         end
         // first block seeds the moving average, weight saturates at one
         if (!ema_seeded) begin
            ema_pct = MOIST_W'(raw);
            ema_seeded = 1'b1;
         end else begin
            w = (ema_weight > WEIGHT_ONE) ? 256 : 32'(ema_weight);
            next_ema = (w * raw + (256 - w) * 32'(ema_pct)) >> 8;
            ema_pct = MOIST_W'(next_ema);
         end
         r.mean_code = ADC_W'(mean);
         r.raw_pct   = MOIST_W'(raw);
         r.ema_pct   = ema_pct;
         expected_readings.push_back(r);
      end
   endtask

   // gap after a burst: often none, sometimes short, rarely long
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 9);
      if (r < 4) return 0;
      if (r < 9) return $urandom_range(1, 5);
      return $urandom_range(10, 30);
   endfunction

   // sample driver, bursts and gaps
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         gap_left   <= 0;
         burst_left <= 0;
      end else if (!req_tvalid || req_tready) begin
         if (gap_left > 0) begin
            gap_left   <= gap_left - 1;
            req_tvalid <= 1'b0;
         end else if (sample_queue.size() > 0) begin
            req_tvalid <= 1'b1;
            req_tdata  <= REQ_DATA_W'(sample_queue.pop_front());
            if (burst_left <= 1) begin
               burst_left <= $urandom_range(1, 24);
               gap_left   <= pick_gap();
            end else begin
               burst_left <= burst_left - 1;
            end
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // result receiver, random stall pattern plus two long hold-offs
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else if (hold_count < 2 && accepted_words >= (hold_count == 0 ? 500 : 1100)) begin
         hold_left  <= HOLD_CYCLES;
         hold_count <= hold_count + 1;
         rsp_tready <= 1'b0;
      end else begin
         if (pattern_left == 0) begin
            pattern_mode <= $urandom_range(0, 3);
            pattern_left <= $urandom_range(20, 300);
         end else begin
            pattern_left <= pattern_left - 1;
         end
         case (pattern_mode)
            0: rsp_tready <= 1'b1;
            1: rsp_tready <= ($urandom_range(0, 1) == 0);
            2: rsp_tready <= ($urandom_range(0, 3) == 0);
            default: rsp_tready <= ($urandom_range(0, 9) != 0);
         endcase
      end
   end

   // monitor: check result words, predict from accepted sample words
   always @(posedge clock) begin
      moisture_reading_type want, got;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            got.mean_code = rsp_tdata[11:0];
            got.raw_pct   = rsp_tdata[26:12];
            got.ema_pct   = rsp_tdata[41:27];
            got.calib_bad = rsp_tuser;
            if (expected_readings.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected result word: mean %0d raw %0d ema %0d err %0b",
                           got.mean_code, got.raw_pct, got.ema_pct, got.calib_bad);
            end else begin
               want = expected_readings.pop_front();
               if (got.mean_code !== want.mean_code || got.raw_pct !== want.raw_pct ||
                   got.ema_pct !== want.ema_pct || got.calib_bad !== want.calib_bad) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch: exp mean %0d raw %0d ema %0d err %0b, got %0d %0d %0d %0b",
                              want.mean_code, want.raw_pct, want.ema_pct, want.calib_bad,
                              got.mean_code, got.raw_pct, got.ema_pct, got.calib_bad);
               end
            end
         end
         if (req_tvalid && req_tready) begin
            accumulate_sample(req_tdata[ADC_W-1:0]);
            accepted_words <= accepted_words + 1;
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // one register write, predictor copy follows at once
   task automatic write_reg(input logic [CSR_ADDR_W-1:0] idx, input logic [CFG_W-1:0] value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= value;
      case (idx)
         CSR_DRY:    dry_code = value;
         CSR_WET:    wet_code = value;
         CSR_WEIGHT: ema_weight = value[WEIGHT_W-1:0];
         default: ;
      endcase
   endtask

   task automatic set_calibration(input logic [CFG_W-1:0] dry, input logic [CFG_W-1:0] wet,
                                  input logic [CFG_W-1:0] weight, input bit poke_spare);
      write_reg(CSR_DRY, dry);
      write_reg(CSR_WET, wet);
      write_reg(CSR_WEIGHT, weight);
      if (poke_spare) write_reg(CSR_SPARE, CFG_W'($urandom));
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // wait until no word is in flight or owed, then let the block settle
   task automatic wait_idle();
      do begin
         @(posedge clock);
         #1;
      end while (sample_queue.size() != 0 || req_tvalid || expected_readings.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // random samples, one shape per block: spread around the calibration span,
   // exactly on a calibration code, pinned at a rail or fully uniform
   task automatic queue_samples(input int count);
      int mode, lo, hi, center, spread, v;
      lo = (wet_code < dry_code) ? int'(wet_code) : int'(dry_code);
      hi = (wet_code < dry_code) ? int'(dry_code) : int'(wet_code);
      mode = 0;
      center = 0;
      spread = 0;
      for (int i = 0; i < count; i++) begin
         if (i % SAMPLES == 0) begin
            mode = $urandom_range(0, 9);
            case (mode)
               1: begin
                  center = $urandom_range(0, 1) ? ADC_MAX : 0;
                  spread = 0;
               end
               2: begin
                  center = $urandom_range(0, 1) ? hi : lo;
                  spread = 0;
               end
               default: begin
                  center = $urandom_range((lo > 48) ? lo - 48 : 0,
                                          (hi < ADC_MAX - 48) ? hi + 48 : ADC_MAX);
                  spread = $urandom_range(0, 96);
               end
            endcase
         end
         if (mode == 0) begin
            v = $urandom_range(0, ADC_MAX);
         end else begin
            v = center + int'($urandom_range(0, 2 * spread)) - spread;
            if (v < 0) v = 0;
            if (v > ADC_MAX) v = ADC_MAX;
         end
         sample_queue.push_back(ADC_W'(v));
      end
   endtask

   // stimulus and end of run
   initial begin
      int          leftover;
      logic [CFG_W-1:0] dry, wet, weight;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed block at reset calibration: rails and alternating bit patterns
      sample_queue.push_back(12'd0);
      sample_queue.push_back(12'hFFF);
      sample_queue.push_back(12'hAAA);
      sample_queue.push_back(12'h555);
      repeat (SAMPLES - 4) sample_queue.push_back(12'hFFF);
      wait_idle();

      for (int p = 0; p < PHASES; p++) begin
         case (p)
            0: begin dry = 12'd4095; wet = 12'd0;    weight = 12'd256; end
            1: begin dry = 12'd0;    wet = 12'd4095; weight = 12'd0;   end
            2: begin dry = 12'd2000; wet = 12'd2000; weight = 12'd511; end
            3: begin dry = 12'd1;    wet = 12'd0;    weight = 12'hE33; end
            4: begin dry = 12'd4095; wet = 12'd4094; weight = 12'd1;   end
            5: begin dry = 12'd3000; wet = 12'd1200; weight = 12'd300; end
            default: begin
               dry = CFG_W'($urandom_range(0, ADC_MAX));
               wet = CFG_W'($urandom_range(0, ADC_MAX));
               // mostly a valid span, now and then a swapped one
               if (dry < wet && $urandom_range(0, 6) != 0) begin
                  weight = dry;
                  dry = wet;
                  wet = weight;
               end
               weight = $urandom_range(0, 3) == 0 ? CFG_W'($urandom_range(0, 4095))
                                                  : CFG_W'($urandom_range(0, 300));
            end
         endcase
         set_calibration(dry, wet, weight, (p % 3) == 1);
         queue_samples(PHASE_WORDS);
         wait_idle();
      end

      leftover = expected_readings.size();
      if (leftover != 0) $display("%0d readings never arrived", leftover);
      if (mismatches == 0 && leftover == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
